>>> rtl/core/enveloped_sine_tone_mixer_macros.svh
// assertion macros shared by the checker of the tone mixer
// expects clk and arst_n to exist where the macros are used
`ifndef ENVELOPED_SINE_TONE_MIXER_MACROS_SVH
`define ENVELOPED_SINE_TONE_MIXER_MACROS_SVH

// same-cycle implication, off while in reset
`define ESTM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define ESTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// implication that also watches the cycles around reset
`define ESTM_ASSERT_RESET(label, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/estm_pkg.sv
// shared types, constants and the sine rom builder of the tone mixer
// no dependencies
`timescale 1ns / 1ps

package estm_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int AMP_BITS        = 16;
	localparam int RAMP_BITS       = 16;
	localparam int INDEX_BITS      = 24;
	localparam int COUNT_BITS      = 25;
	localparam int CFG_DATA_BITS   = 32;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;
	localparam int QUARTER         = TABLE_SIZE / 4;
	localparam int FIFO_DEPTH      = 2;
	localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);

	localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int SAMPLE_MIN = -(1 << (SAMPLE_BITS - 1));

	// back end datapath widths
	localparam int SCALED_BITS = SAMPLE_BITS + AMP_BITS + 1;
	localparam int PROD_BITS   = SCALED_BITS + COUNT_BITS;
	localparam int QUOT_BITS   = PROD_BITS - AMP_BITS;
	localparam int DIV_STEPS   = QUOT_BITS / 2;
	localparam int STEP_BITS   = $clog2(DIV_STEPS);
	localparam int SUM_BITS    = QUOT_BITS + 2;

	localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS - 1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS - 1){1'b0}}};

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	// (2k)(2k+1) for the terms of the sine series
	localparam longint unsigned SERIES_DIV [1:12] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PHASE_INCREMENT,
		REG_AMPLITUDE,
		REG_RAMP_LENGTH,
		REG_NOTE_LENGTH
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] phase_increment;
		logic [AMP_BITS-1:0]      amplitude;
		logic [RAMP_BITS-1:0]     ramp_length;
		logic [INDEX_BITS-1:0]    note_length;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mix_in;
		logic                          note_start;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mix_out;
		logic                          last_of_note;
	} result_t;

	// one classified sample handed from front to back
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mix_in;
		logic [TABLE_ADDR_BITS-1:0]    addr;
		logic signed [COUNT_BITS-1:0]  count;
		logic                          last;
	} job_t;

	typedef logic signed [SAMPLE_BITS-1:0] sine_rom_t [TABLE_SIZE];

	// a zero ramp length acts as one
	function automatic logic [RAMP_BITS-1:0] eff_ramp(input logic [RAMP_BITS-1:0] r);
		return (r == '0) ? RAMP_BITS'(1) : r;
	endfunction

	// rounded quarter wave point from a taylor series in q30
	function automatic logic signed [SAMPLE_BITS-1:0] quarter_sine(input int unsigned q);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] v;
		longint sum;
		int k;
		x = (HALF_PI_Q30 * 64'(q)) / QUARTER;
		term = x;
		sum = longint'(x);
		for (k = 1; k <= 12; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / SERIES_DIV[k];
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		v = (64'(sum) * 64'(SAMPLE_MAX) + (64'd1 << 29)) >> 30;
		if (v > 64'(SAMPLE_MAX))
			v = 64'(SAMPLE_MAX);
		return v[SAMPLE_BITS-1:0];
	endfunction

	// full wave mirrored from the quarter wave
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [1:0] quad;
		int unsigned r;
		logic signed [SAMPLE_BITS-1:0] s;
		for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
			quad = 2'(i / QUARTER);
			r = i % QUARTER;
			s = quad[0] ? quarter_sine(QUARTER - r) : quarter_sine(r);
			rom[i] = quad[1] ? -s : s;
		end
		return rom;
	endfunction

endpackage

>>> rtl/core/estm_front.sv
// front end: takes samples, steps phase, sample index and envelope count
// depends on estm_pkg
`timescale 1ns / 1ps

module estm_front import estm_pkg::*; #(
	parameter int PHASE_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	input  logic  fifo_full,
	output logic  push,
	output job_t  job
);

	logic [PHASE_BITS-1:0] phase_q, phase_cur, phase_step;
	logic [PHASE_BITS+CFG_DATA_BITS-1:0] step_ext;
	logic [INDEX_BITS-1:0] index_q, index_cur, last_index, ramp_m1;
	logic [INDEX_BITS:0] note_len;
	logic [INDEX_BITS+1:0] release_start;
	logic [RAMP_BITS-1:0] ramp;
	logic signed [COUNT_BITS-1:0] count_q, count_cur, count_up, count_next;
	logic last, rising, falling;

	assign item_stall = fifo_full;
	assign push = item_valid && !fifo_full;

	always_comb begin
		phase_cur = item.note_start ? '0 : phase_q;
		index_cur = item.note_start ? '0 : index_q;
		count_cur = item.note_start ? '0 : count_q;

		// zero note length means a full 2^24 sample note
		last_index = cfg.note_length - INDEX_BITS'(1);
		note_len = (cfg.note_length == '0) ? {1'b1, {INDEX_BITS{1'b0}}}
			: {1'b0, cfg.note_length};
		ramp = eff_ramp(cfg.ramp_length);
		ramp_m1 = {{(INDEX_BITS - RAMP_BITS){1'b0}}, ramp - RAMP_BITS'(1)};
		release_start = {1'b0, note_len} - (INDEX_BITS + 2)'(ramp);

		rising = index_cur < ramp_m1;
		// negative release start means the release covers the whole note
		falling = release_start[INDEX_BITS+1]
			|| ({1'b0, index_cur} >= release_start[INDEX_BITS:0]);
		count_up = (rising && count_cur != COUNT_MAX) ? count_cur + COUNT_BITS'(1)
			: count_cur;
		count_next = (falling && count_up != COUNT_MIN) ? count_up - COUNT_BITS'(1)
			: count_up;
		last = index_cur == last_index;

		step_ext = (PHASE_BITS + CFG_DATA_BITS)'(cfg.phase_increment);
		phase_step = step_ext[PHASE_BITS-1:0];

		job.mix_in = item.mix_in;
		job.addr = phase_cur[PHASE_BITS-1 -: TABLE_ADDR_BITS];
		job.count = count_cur;
		job.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			index_q <= '0;
			count_q <= '0;
		end else if (push) begin
			if (last) begin
				// next note starts by itself
				phase_q <= '0;
				index_q <= '0;
				count_q <= '0;
			end else begin
				phase_q <= phase_cur + phase_step;
				index_q <= index_cur + INDEX_BITS'(1);
				count_q <= count_next;
			end
		end
	end

endmodule

>>> rtl/core/estm_fifo.sv
// small job queue between front and back end
// depends on estm_pkg
`timescale 1ns / 1ps

module estm_fifo import estm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t rd_job
);

	job_t entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_BITS:0] fill_q;

	assign full = fill_q == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH);
	assign empty = fill_q == '0;
	assign rd_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			if (push && !pop)
				fill_q <= fill_q + (FIFO_PTR_BITS + 1)'(1);
			else if (pop && !push)
				fill_q <= fill_q - (FIFO_PTR_BITS + 1)'(1);
		end
	end

endmodule

>>> rtl/core/estm_back.sv
// back end: sine rom, gain and envelope multiplies, ramp divider, saturating mix
// depends on estm_pkg
`timescale 1ns / 1ps

module estm_back import estm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    fifo_empty,
	input  job_t    fifo_job,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam logic signed [SUM_BITS-1:0] SUM_MAX = SAMPLE_MAX;
	localparam logic signed [SUM_BITS-1:0] SUM_MIN = SAMPLE_MIN;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SCALE,
		S_ENVELOPE,
		S_MAGNITUDE,
		S_DIVIDE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic [STEP_BITS-1:0] iter_q;
	logic result_valid_q;
	result_t result_q;

	logic [TABLE_ADDR_BITS-1:0] addr_q;
	logic signed [SAMPLE_BITS-1:0] rom_q, mix_in_q;
	logic signed [COUNT_BITS-1:0] count_q;
	logic last_q, neg_q;
	logic signed [SCALED_BITS-1:0] scaled_q;
	logic signed [PROD_BITS-1:0] product_q;
	logic [PROD_BITS-1:0] mag;
	logic [QUOT_BITS-1:0] quot_q, quot_next;
	logic [RAMP_BITS-1:0] rem_q, rem1, rem2, divisor;
	logic [RAMP_BITS:0] trial1, trial2, diff1, diff2;
	logic bit1, bit2;
	logic signed [SUM_BITS-1:0] mix_ext, tone_ext, sum;
	result_t mixed;
	logic out_free;

	assign pop = (state_q == S_IDLE) && !fifo_empty;
	assign out_free = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		mag = product_q[PROD_BITS-1] ? -product_q : product_q;

		// restoring divide, two quotient bits per cycle
		divisor = eff_ramp(cfg.ramp_length);
		trial1 = {rem_q, quot_q[QUOT_BITS-1]};
		diff1 = trial1 - {1'b0, divisor};
		bit1 = !diff1[RAMP_BITS];
		rem1 = bit1 ? diff1[RAMP_BITS-1:0] : trial1[RAMP_BITS-1:0];
		trial2 = {rem1, quot_q[QUOT_BITS-2]};
		diff2 = trial2 - {1'b0, divisor};
		bit2 = !diff2[RAMP_BITS];
		rem2 = bit2 ? diff2[RAMP_BITS-1:0] : trial2[RAMP_BITS-1:0];
		quot_next = {quot_q[QUOT_BITS-3:0], bit1, bit2};

		mix_ext = SUM_BITS'(mix_in_q);
		tone_ext = {2'b00, quot_q};
		sum = neg_q ? mix_ext - tone_ext : mix_ext + tone_ext;
		if (sum > SUM_MAX)
			mixed.mix_out = SUM_MAX[SAMPLE_BITS-1:0];
		else if (sum < SUM_MIN)
			mixed.mix_out = SUM_MIN[SAMPLE_BITS-1:0];
		else
			mixed.mix_out = sum[SAMPLE_BITS-1:0];
		mixed.last_of_note = last_q;
	end

	always_ff @(posedge clk) begin
		rom_q <= SINE_ROM[addr_q];
		if (pop) begin
			addr_q <= fifo_job.addr;
			mix_in_q <= fifo_job.mix_in;
			count_q <= fifo_job.count;
			last_q <= fifo_job.last;
		end
		unique case (state_q)
			S_SCALE: begin
				scaled_q <= rom_q * $signed({1'b0, cfg.amplitude});
			end
			S_ENVELOPE: begin
				product_q <= scaled_q * count_q;
			end
			S_MAGNITUDE: begin
				// truncation toward zero: divide the magnitude, sign goes on at the mix
				neg_q <= product_q[PROD_BITS-1];
				quot_q <= mag[PROD_BITS-1:AMP_BITS];
				rem_q <= '0;
			end
			S_DIVIDE: begin
				quot_q <= quot_next;
				rem_q <= rem2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			result_valid_q <= 1'b0;
			result_q <= '0;
		end else begin
			if (result_valid_q && !result_stall && state_q != S_HOLD)
				result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!fifo_empty)
						state_q <= S_READ;
				end
				S_READ: state_q <= S_SCALE;
				S_SCALE: state_q <= S_ENVELOPE;
				S_ENVELOPE: state_q <= S_MAGNITUDE;
				S_MAGNITUDE: begin
					iter_q <= '0;
					state_q <= S_DIVIDE;
				end
				S_DIVIDE: begin
					iter_q <= iter_q + STEP_BITS'(1);
					if (iter_q == STEP_BITS'(DIV_STEPS - 1))
						state_q <= S_HOLD;
				end
				S_HOLD: begin
					// load the output register once it is empty or being taken
					if (out_free) begin
						result_q <= mixed;
						result_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/enveloped_sine_tone_mixer.sv
// top level of the enveloped sine tone mixer: config registers, front, queue, back
// depends on estm_pkg, estm_front, estm_fifo, estm_back
// usage:
//   item channel (item_valid, item_stall, item) carries mix_in and note_start;
//   result channel (result_valid, result_stall, result) returns mix_out and
//   last_of_note, one result per item, in order. a transfer happens at a clock
//   edge with valid high and stall low.
//   cfg_we, cfg_index, cfg_data write phase_increment, amplitude, ramp_length
//   and note_length; write them only while no item is in flight.
//   the front end steps phase, sample index and envelope in the cycle an item
//   is taken and queues it (two deep); input stalls only when the queue is full.
//   the back end works on one item at a time: it takes the item from the queue,
//   reads the rom, does two multiplies, takes the magnitude, runs a
//   two-bit-per-cycle restoring divide by ramp_length, then does the saturating
//   add into the output register, and only then takes the next item from the
//   queue. a stalled result holds while the back end finishes the next item and
//   the queue keeps taking items.
//   reset clears phase, index, envelope, the queue and the output register, and
//   loads the register defaults (amplitude 0.5, ramp 1000, note 44100).
`timescale 1ns / 1ps

module enveloped_sine_tone_mixer import estm_pkg::*; #(
	parameter int PHASE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  item_t                     item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output result_t                   result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t cfg_q;
	job_t front_job, queue_job;
	logic push, pop, fifo_full, fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_increment <= '0;
			cfg_q.amplitude <= AMP_BITS'(32768);
			cfg_q.ramp_length <= RAMP_BITS'(1000);
			cfg_q.note_length <= INDEX_BITS'(44100);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PHASE_INCREMENT: cfg_q.phase_increment <= cfg_data;
				REG_AMPLITUDE:       cfg_q.amplitude <= cfg_data[AMP_BITS-1:0];
				REG_RAMP_LENGTH:     cfg_q.ramp_length <= cfg_data[RAMP_BITS-1:0];
				REG_NOTE_LENGTH:     cfg_q.note_length <= cfg_data[INDEX_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	estm_front #(
		.PHASE_BITS(PHASE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.fifo_full  (fifo_full),
		.push       (push),
		.job        (front_job)
	);

	estm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (front_job),
		.full   (fifo_full),
		.pop    (pop),
		.empty  (fifo_empty),
		.rd_job (queue_job)
	);

	estm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.fifo_empty   (fifo_empty),
		.fifo_job     (queue_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> rtl/core/estm_checker.sv
// port level checks for the tone mixer, bound to the top level
// depends on estm_pkg and enveloped_sine_tone_mixer_macros.svh
`timescale 1ns / 1ps
`include "enveloped_sine_tone_mixer_macros.svh"

module estm_checker import estm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	logic result_xfer;

	assign result_xfer = result_valid && !result_stall;

	// queue and output register come out of reset empty
	`ESTM_ASSERT_RESET(a_reset_empty, $past(!arst_n), !result_valid && !item_stall, "not empty after reset")

	`ESTM_ASSERT_NEXT(a_stall_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

	`ESTM_ASSERT_NOW(a_drop_after_xfer, $fell(result_valid), $past(!result_stall), "result dropped without transfer")

	// at most the held result and one waiting in the back end go out back to back
	`ESTM_ASSERT_NEXT(a_burst_limit, result_xfer ##1 result_xfer, !result_valid, "third result too early")

endmodule

bind enveloped_sine_tone_mixer estm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
